// File: rtl/core/wsr_pkg.sv
// Shared types and constants for the window statistics and trend run unit.
package wsr_pkg;

    localparam int SAMPLE_W   = 14;
    localparam int SUM_W      = 26;
    localparam int SQ_W       = 41;
    localparam int SQ_OUT_W   = 40;
    localparam int RSUM_W     = 20;
    localparam int RTOT_W     = 19;
    localparam int COUNT_W    = 16;
    localparam int PROD_W     = 2 * SAMPLE_W;

    localparam int WINDOW_DEF = 4096;
    localparam int RUNS_DEF   = 8;

    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 88;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;

    // register index taken from paddr[2]
    localparam logic REG_TREND_TOL = 1'b0;

    localparam logic [SAMPLE_W-1:0] TOL_RESET = SAMPLE_W'(8);
    localparam logic [COUNT_W-1:0]  COUNT_MAX = '1;

    typedef struct packed {
        logic                fire;
        logic [SAMPLE_W-1:0] sample;
    } step_t;

endpackage

// File: rtl/core/wsr_window.sv
// Sample window store with running sum and running sum of squares.
module wsr_window #(
    parameter int WINDOW = wsr_pkg::WINDOW_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  wsr_pkg::step_t           step,
    output logic [wsr_pkg::SUM_W-1:0] sum_next,
    output logic [wsr_pkg::SQ_W-1:0]  sq_next
);
    import wsr_pkg::*;

    localparam int WP_W = $clog2(WINDOW);

    logic [SAMPLE_W-1:0] mem [WINDOW];
    logic [SAMPLE_W-1:0] old_reg;
    logic [WP_W-1:0]     wp_reg;
    logic [WP_W-1:0]     wp_next;
    logic                wrap_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [SQ_W-1:0]     sq_reg;
    logic                wp_last;
    logic [SAMPLE_W-1:0] old_val;
    logic [PROD_W-1:0]   old_sq;
    logic [PROD_W-1:0]   new_sq;

    assign wp_last = (wp_reg == WP_W'(WINDOW - 1));

    always_comb
    begin
        wp_next = wp_reg;
        if (step.fire)
        begin
            wp_next = wp_last ? '0 : wp_reg + 1'b1;
        end
    end

    // entries not yet written since reset read as zero
    assign old_val  = wrap_reg ? old_reg : '0;
    assign old_sq   = PROD_W'(old_val) * PROD_W'(old_val);
    assign new_sq   = PROD_W'(step.sample) * PROD_W'(step.sample);
    assign sum_next = sum_reg - SUM_W'(old_val) + SUM_W'(step.sample);
    assign sq_next  = sq_reg - SQ_W'(old_sq) + SQ_W'(new_sq);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= '0;
            wrap_reg <= 1'b0;
            sum_reg  <= '0;
            sq_reg   <= '0;
        end
        else if (step.fire)
        begin
            wp_reg  <= wp_next;
            sum_reg <= sum_next;
            sq_reg  <= sq_next;
            if (wp_last)
            begin
                wrap_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step.fire)
        begin
            mem[wp_reg] <= step.sample;
        end
    end

    // prefetch the entry the next sample will overwrite
    always_ff @(posedge clk)
    begin
        old_reg <= mem[wp_next];
    end

endmodule

// File: rtl/core/wsr_trend.sv
// Rising/falling trend tracking with a ring of finished run lengths.
module wsr_trend #(
    parameter int RUNS = wsr_pkg::RUNS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  wsr_pkg::step_t               step,
    input  logic [wsr_pkg::SAMPLE_W-1:0] tolerance,
    output logic [wsr_pkg::RSUM_W-1:0]   run_sum_next,
    output logic                         ended
);
    import wsr_pkg::*;

    localparam int RP_W = (RUNS > 1) ? $clog2(RUNS) : 1;

    logic [COUNT_W-1:0]  run_mem [RUNS];
    logic [COUNT_W-1:0]  run_rd_reg;
    logic [RUNS-1:0]     run_vld_reg;
    logic [RP_W-1:0]     rp_reg;
    logic [RP_W-1:0]     rp_next;
    logic [RSUM_W-1:0]   run_sum_reg;
    logic [SAMPLE_W-1:0] prev_reg;
    logic                rising_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic [COUNT_W-1:0]  count_next;
    logic [SAMPLE_W:0]   s_plus_tol;
    logic [SAMPLE_W:0]   p_plus_tol;
    logic                cont;
    logic [COUNT_W-1:0]  run_old;

    assign s_plus_tol = {1'b0, step.sample} + {1'b0, tolerance};
    assign p_plus_tol = {1'b0, prev_reg} + {1'b0, tolerance};
    assign cont = rising_reg ? (s_plus_tol > {1'b0, prev_reg})
                             : ({1'b0, step.sample} < p_plus_tol);
    assign ended = step.fire && !cont;

    always_comb
    begin
        rp_next = rp_reg;
        if (ended)
        begin
            rp_next = (rp_reg == RP_W'(RUNS - 1)) ? '0 : rp_reg + 1'b1;
        end
    end

    always_comb
    begin
        if (!cont)
        begin
            count_next = COUNT_W'(1);
        end
        else if (count_reg == COUNT_MAX)
        begin
            count_next = count_reg;
        end
        else
        begin
            count_next = count_reg + 1'b1;
        end
    end

    assign run_old = run_vld_reg[rp_reg] ? run_rd_reg : '0;

    always_comb
    begin
        run_sum_next = run_sum_reg;
        if (ended)
        begin
            run_sum_next = run_sum_reg - RSUM_W'(run_old) + RSUM_W'(count_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg    <= '0;
            rising_reg  <= 1'b0;
            count_reg   <= '0;
            rp_reg      <= '0;
            run_sum_reg <= '0;
            run_vld_reg <= '0;
        end
        else if (step.fire)
        begin
            prev_reg  <= step.sample;
            count_reg <= count_next;
            if (ended)
            begin
                rising_reg          <= !rising_reg;
                rp_reg              <= rp_next;
                run_sum_reg         <= run_sum_next;
                run_vld_reg[rp_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ended)
        begin
            run_mem[rp_reg] <= count_reg;
        end
    end

    // prefetch the ring entry the next run will replace; bypass a single-entry ring
    always_ff @(posedge clk)
    begin
        if (ended && (rp_next == rp_reg))
        begin
            run_rd_reg <= count_reg;
        end
        else
        begin
            run_rd_reg <= run_mem[rp_next];
        end
    end

endmodule

// File: rtl/core/window_stats_and_trend_runs_unit.sv
// Top level: stream ports, tolerance register, input and result registers.
// Usage:
//   Slave stream (s_*) carries one 14-bit unsigned sample per transfer in
//   s_tdata[13:0]. Master stream (m_*) carries one result per sample: the
//   sum and the sum of squares of the last WINDOW samples, the total of the
//   last RUNS finished trend-run lengths, and in m_tuser a flag set when the
//   sample ended a rising or falling run.
//   A result is registered: the input register loads at the sample transfer,
//   and the result register loads from it once it is free or m_tready is high.
//   Throughput: one sample per cycle while m_tready stays high; the window memory is
//   read one item ahead, so its single read port and one squaring unit per operand set the rate.
//   Reset clears the window (entries read as zero until first written), the
//   sums, the run ring and the trend state; the tolerance returns to 8. No
//   clearing pass is needed, samples are taken right after reset.
//   When the receiver holds m_tready low, the result register holds and the
//   input register still takes one more sample; s_tready then drops until
//   the result transfer frees a slot.
//   The APB port writes trend_tolerance at address 0 (low 14 bits used).
module window_stats_and_trend_runs_unit #(
    parameter int WINDOW = wsr_pkg::WINDOW_DEF,
    parameter int RUNS   = wsr_pkg::RUNS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // s_tdata: sample [13:0], zero pad [15:14]
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [wsr_pkg::IN_TDATA_W-1:0]  s_tdata,
    // m_tdata: window_sum [25:0], square_sum [65:26], run_total [84:66], zero pad [87:85]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [wsr_pkg::OUT_TDATA_W-1:0] m_tdata,
    // m_tuser: run_ended [0]
    output logic                            m_tuser,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [wsr_pkg::PADDR_W-1:0]     paddr,
    input  logic [wsr_pkg::PDATA_W-1:0]     pwdata,
    output logic [wsr_pkg::PDATA_W-1:0]     prdata,
    output logic                            pready
);
    import wsr_pkg::*;

    logic                     in_valid_reg;
    logic [SAMPLE_W-1:0]      in_sample_reg;
    logic                     out_valid_reg;
    logic [OUT_TDATA_W-1:0]   out_data_reg;
    logic                     out_user_reg;
    logic [SAMPLE_W-1:0]      tol_reg;
    logic                     advance;
    logic                     in_take;
    step_t                    step;
    logic [SUM_W-1:0]         sum_next;
    logic [SQ_W-1:0]          sq_next;
    logic [RSUM_W-1:0]        run_sum_next;
    logic                     ended;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    assign step = '{fire: advance, sample: in_sample_reg};

    wsr_window #(
        .WINDOW (WINDOW)
    ) u_window (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .sum_next (sum_next),
        .sq_next  (sq_next)
    );

    wsr_trend #(
        .RUNS (RUNS)
    ) u_trend (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .tolerance    (tol_reg),
        .run_sum_next (run_sum_next),
        .ended        (ended)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_sample_reg <= s_tdata[SAMPLE_W-1:0];
        end
        if (advance)
        begin
            out_data_reg <= {3'b000, run_sum_next[RTOT_W-1:0],
                             sq_next[SQ_OUT_W-1:0], sum_next};
            out_user_reg <= ended;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    // configuration: one register, index from paddr[2]
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= TOL_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_TREND_TOL))
        begin
            tol_reg <= pwdata[SAMPLE_W-1:0];
        end
    end

    assign pready = 1'b1;

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_TREND_TOL)
        begin
            prdata = PDATA_W'(tol_reg);
        end
    end

endmodule

// File: tb/window_stats_and_trend_runs_unit_test.sv
// Self-checking bench for the window statistics and trend run unit: stream and register traffic.
module window_stats_and_trend_runs_unit_test;
    import wsr_pkg::*;

    localparam int QUIET_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_HALF   = 120;
    localparam int LONG_RUN      = 60;

    localparam logic [PADDR_W-1:0] TOL_ADDR   = PADDR_W'(0);
    localparam logic [PADDR_W-1:0] SPARE_ADDR = PADDR_W'(4);

    typedef struct {
        bit [SUM_W-1:0]    window_sum;
        bit [SQ_OUT_W-1:0] square_sum;
        bit [RTOT_W-1:0]   run_total;
        bit                run_ended;
    } window_stats_t;

    class window_trend_scoreboard;
        bit [SAMPLE_W-1:0] samples [WINDOW_DEF];
        int unsigned       wr_idx;
        bit [SUM_W-1:0]    level_sum;
        bit [SQ_W-1:0]     energy_sum;
        bit                rising;
        bit [COUNT_W-1:0]  run_len;
        bit [COUNT_W-1:0]  run_ring [RUNS_DEF];
        int unsigned       ring_idx;
        bit [RSUM_W-1:0]   ring_sum;
        bit [SAMPLE_W-1:0] tolerance;
        window_stats_t     owed_stats[$];
        int                fail_count;

        function new();
            tolerance = TOL_RESET;
        endfunction

        function void take_sample(bit [SAMPLE_W-1:0] s);
            bit [SAMPLE_W-1:0] old_s;
            bit [SQ_W-1:0]     old_w;
            bit [SQ_W-1:0]     new_w;
            bit [SAMPLE_W:0]   s_x;
            bit [SAMPLE_W:0]   prev_x;
            bit [SAMPLE_W:0]   tol_x;
            bit                carry_on;
            int unsigned       prev_idx;
            window_stats_t     r;
            old_s = samples[wr_idx];
            old_w = SQ_W'(old_s);
            new_w = SQ_W'(s);
            level_sum  = level_sum - SUM_W'(old_s) + SUM_W'(s);
            energy_sum = energy_sum - old_w * old_w + new_w * new_w;
            samples[wr_idx] = s;
            prev_idx = (wr_idx == 0) ? WINDOW_DEF - 1 : wr_idx - 1;
            // compare at one bit wider so the tolerance sum cannot wrap
            s_x    = {1'b0, s};
            prev_x = {1'b0, samples[prev_idx]};
            tol_x  = {1'b0, tolerance};
            carry_on = rising ? (s_x + tol_x > prev_x) : (s_x < prev_x + tol_x);
            if (carry_on)
            begin
                if (run_len != COUNT_MAX)
                    run_len++;
            end
            else
            begin
                ring_sum = ring_sum - RSUM_W'(run_ring[ring_idx]) + RSUM_W'(run_len);
                run_ring[ring_idx] = run_len;
                ring_idx = (ring_idx == RUNS_DEF - 1) ? 0 : ring_idx + 1;
                rising   = !rising;
                run_len  = COUNT_W'(1);
            end
            wr_idx = (wr_idx == WINDOW_DEF - 1) ? 0 : wr_idx + 1;
            r.window_sum = level_sum;
            r.square_sum = energy_sum[SQ_OUT_W-1:0];
            r.run_total  = ring_sum[RTOT_W-1:0];
            r.run_ended  = !carry_on;
            owed_stats.push_back(r);
        endfunction

        function void compare_field(string label, logic [63:0] want, logic [63:0] got);
            if (got !== want)
            begin
                $display("%0t: %s expected %0d actual %0d", $time, label, want, got);
                fail_count++;
            end
        endfunction

        function void match_result(logic [OUT_TDATA_W-1:0] data, logic flag);
            window_stats_t want;
            if (owed_stats.size() == 0)
            begin
                $display("%0t: result with none outstanding, expected nothing actual tdata=%h",
                         $time, data);
                fail_count++;
                return;
            end
            want = owed_stats.pop_front();
            compare_field("window_sum", 64'(want.window_sum), 64'(data[SUM_W-1:0]));
            compare_field("square_sum", 64'(want.square_sum), 64'(data[SUM_W +: SQ_OUT_W]));
            compare_field("run_total", 64'(want.run_total),
                          64'(data[SUM_W+SQ_OUT_W +: RTOT_W]));
            compare_field("run_ended", 64'(want.run_ended), 64'(flag));
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;    // sample [13:0], zero pad [15:14]
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;    // window_sum [25:0], square_sum [65:26], run_total [84:66]
    logic                   m_tuser;    // run_ended [0]
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [PADDR_W-1:0]     paddr;
    logic [PDATA_W-1:0]     pwdata;
    logic [PDATA_W-1:0]     prdata;
    logic                   pready;

    window_trend_scoreboard tracker = new();

    int send_idle_pct;
    int recv_idle_pct;
    int walk_level;
    int walk_left;
    int walk_step;
    bit walk_up;

    window_stats_and_trend_runs_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // result side: check each transfer, then pick the next ready level
    initial
    begin
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                tracker.match_result(m_tdata, m_tuser);
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("window_stats_and_trend_runs_unit test failed");
                $finish;
            end
        end
    end

    task automatic apb_access(input logic [PADDR_W-1:0] addr, input logic write,
                              input logic [PDATA_W-1:0] wdata,
                              output logic [PDATA_W-1:0] rdata);
        psel   <= 1'b1;
        pwrite <= write;
        paddr  <= addr;
        pwdata <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rdata = prdata;
        penable <= 1'b0;
        if (write && addr == TOL_ADDR)
            tracker.tolerance = wdata[SAMPLE_W-1:0];
    endtask

    // optional tolerance write, optional write to the unused slot, then read back
    task automatic update_tolerance(input bit write_main, input bit write_spare,
                                    input logic [SAMPLE_W-1:0] tol);
        logic [PDATA_W-1:0] word;
        logic [PDATA_W-1:0] readback;
        word = $urandom();
        word[SAMPLE_W-1:0] = tol;
        if (write_main)
            apb_access(TOL_ADDR, 1'b1, word, readback);
        if (write_spare)
            apb_access(SPARE_ADDR, 1'b1, $urandom(), readback);
        apb_access(TOL_ADDR, 1'b0, '0, readback);
        psel <= 1'b0;
        if (readback[SAMPLE_W-1:0] !== tracker.tolerance)
        begin
            $display("%0t: trend_tolerance expected %0d actual %0d",
                     $time, tracker.tolerance, readback[SAMPLE_W-1:0]);
            tracker.fail_count++;
        end
    endtask

    task automatic send_sample(input logic [SAMPLE_W-1:0] s);
        logic [IN_TDATA_W-1:0] word;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        // pad bits go out random, the unit must ignore them
        word = IN_TDATA_W'($urandom());
        word[SAMPLE_W-1:0] = s;
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        do @(posedge clk); while (!s_tready);
        tracker.take_sample(s);
    endtask

    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (tracker.owed_stats.size() != 0);
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_tolerance();
        case ($urandom_range(3))
            0: return '0;
            1: return '1;
            2: return SAMPLE_W'($urandom_range(31));
            default: return SAMPLE_W'($urandom_range(16383));
        endcase
    endfunction

    // mostly ramps of random length and slope, some noise and rail values
    function automatic logic [SAMPLE_W-1:0] next_sample();
        int pick;
        int lvl;
        if (walk_left == 0)
        begin
            pick = $urandom_range(99);
            if (pick < 15)
                return SAMPLE_W'($urandom_range(16383));
            if (pick < 22)
                return $urandom_range(1) ? '1 : '0;
            walk_left = $urandom_range(24, 1);
            walk_up   = 1'($urandom_range(1));
            walk_step = ($urandom_range(3) == 0) ? $urandom_range(2000) : $urandom_range(40);
        end
        walk_left--;
        lvl = walk_up ? walk_level + int'($urandom_range(walk_step))
                      : walk_level - int'($urandom_range(walk_step));
        if (lvl < 0)
            lvl = 0;
        if (lvl > 16383)
            lvl = 16383;
        walk_level = lvl;
        return SAMPLE_W'(lvl);
    endfunction

    initial
    begin
        logic [SAMPLE_W-1:0] opening [] = '{0, 7, 15, 7, 14, 16383, 16383, 16375, 0, 1, 9, 9};
        logic [SAMPLE_W-1:0] flat_tol [] = '{100, 100, 100, 99, 101, 16383, 0};
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        send_idle_pct = 35;
        recv_idle_pct = 64;
        walk_level = 8000;
        walk_left  = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // reset value, unused slot ignored, boundaries at the default tolerance
        update_tolerance(1'b0, 1'b1, '0);
        foreach (opening[i])
            send_sample(opening[i]);
        wait_results_drained();
        // zero tolerance: equal samples end a run in either direction
        update_tolerance(1'b1, 1'b0, '0);
        foreach (flat_tol[i])
            send_sample(flat_tol[i]);
        wait_results_drained();

        // full tolerance keeps one run going with no gaps on either side
        update_tolerance(1'b1, 1'b1, '1);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < LONG_RUN; i++)
            send_sample(SAMPLE_W'($urandom_range(16382)));
        wait_results_drained();
        update_tolerance(1'b1, 1'b0, '0);
        repeat (4) send_sample(SAMPLE_W'(5000));

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 35 : (phase == 1) ? 64 : 0;
            recv_idle_pct = (phase == 0) ? 64 : (phase == 1) ? 35 : 0;
            for (int half = 0; half < 2; half++)
            begin
                wait_results_drained();
                update_tolerance(1'b1, $urandom_range(1), pick_tolerance());
                for (int i = 0; i < RANDOM_HALF; i++)
                    send_sample(next_sample());
            end
        end

        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (tracker.fail_count == 0 && tracker.owed_stats.size() == 0)
            $display("window_stats_and_trend_runs_unit test passed");
        else
            $display("window_stats_and_trend_runs_unit test failed");
        $finish;
    end

endmodule
